// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ldrpc_pkg.sv =====
`default_nettype none

package ldrpc_pkg;

  localparam int MAX_ITEMS  = 1024;
  localparam int VALUE_BITS = 16;
  localparam int ADDR_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int OUT_W      = 11;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PASS,
    ST_RDI,
    ST_GETI,
    ST_SCAN,
    ST_WR,
    ST_PEEL,
    ST_PEND,
    ST_FIN
  } ldrpc_state_t;

endpackage

`default_nettype wire

// ===== rtl/longest_decreasing_run_and_peel_count_core.sv =====
// Longest strictly decreasing subsequence and peel-pass count.
//
// Input channel: one value per item on in_tdata; in_tlast marks the final
// value of a sequence. Non-last items are taken one per cycle and stored.
// Values beyond the store depth are dropped and flagged as overflow.
// After a last item in_tready drops while the block computes. Each peel pass
// rebuilds the chain-length table (for each remaining element i a scan over
// all j < i, one memory read per cycle through the single read port) and
// then walks the sequence backward once. The number of passes is at most n.
// An already peeled element is skipped in the table build.
// Result channel: one item per sequence, held in an output register, so a
// stalled receiver only blocks the block when the next result is ready.
// Reset (synchronous, rst_n low) empties the store, clears the overflow
// flag and drops any pending result.

`default_nettype none

`include "assert_macros.svh"

module longest_decreasing_run_and_peel_count_core
  import ldrpc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] value
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // [10:0] longest_length,
                                                 // [21:11] pass_count,
                                                 // [22] overflow, [23] zero
);

  ldrpc_state_t state_r, state_nxt;

  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]      i_r, i_nxt;
  logic [CNT_W-1:0]      j_r, j_nxt;
  logic [CNT_W-1:0]      k_r, k_nxt;
  logic [ADDR_W-1:0]     pk_r, pk_nxt;
  logic                  pend_r, pend_nxt;
  logic [VALUE_BITS-1:0] vi_r, vi_nxt;
  logic [CNT_W-1:0]      t_r, t_nxt;
  logic [CNT_W-1:0]      best_r, best_nxt;
  logic [CNT_W-1:0]      level_r, level_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]      passes_r, passes_nxt;
  logic [CNT_W-1:0]      longest_r, longest_nxt;
  logic                  first_r, first_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // memories: one write and one read address per cycle, registered read data
  logic [VALUE_BITS-1:0] val_mem  [MAX_ITEMS];
  logic                  pres_mem [MAX_ITEMS];
  logic [CNT_W-1:0]      tab_mem  [MAX_ITEMS];

  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  logic                  val_we, pres_we, pres_wd, tab_we;
  logic [VALUE_BITS-1:0] val_q;
  logic                  pres_q;
  logic [CNT_W-1:0]      tab_q;

  logic [CNT_W-1:0]      tab_inc;
  logic                  store_ok;
  logic                  take_chain;

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_addr] <= in_tdata[VALUE_BITS-1:0];
    end
    val_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pres_we) begin
      pres_mem[wr_addr] <= pres_wd;
    end
    pres_q <= pres_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[wr_addr] <= t_r;
    end
    tab_q <= tab_mem[rd_addr];
  end

  // compare unit: does element j extend the chain ending at i?
  assign tab_inc    = tab_q + CNT_W'(1);
  assign take_chain = pres_q && (val_q > vi_r) && (tab_inc > t_r);
  assign store_ok   = cnt_r < CNT_W'(MAX_ITEMS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      pend_r      <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      pend_r      <= pend_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    pk_r       <= pk_nxt;
    vi_r       <= vi_nxt;
    t_r        <= t_nxt;
    best_r     <= best_nxt;
    level_r    <= level_nxt;
    rem_r      <= rem_nxt;
    passes_r   <= passes_nxt;
    longest_r  <= longest_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    pk_nxt        = pk_r;
    pend_nxt      = pend_r;
    vi_nxt        = vi_r;
    t_nxt         = t_r;
    best_nxt      = best_r;
    level_nxt     = level_r;
    rem_nxt       = rem_r;
    passes_nxt    = passes_r;
    longest_nxt   = longest_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    in_tready     = 1'b0;
    rd_addr       = i_r[ADDR_W-1:0];
    wr_addr       = i_r[ADDR_W-1:0];
    val_we        = 1'b0;
    pres_we       = 1'b0;
    pres_wd       = 1'b0;
    tab_we        = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        wr_addr   = cnt_r[ADDR_W-1:0];
        if (in_tvalid) begin
          if (store_ok) begin
            val_we  = 1'b1;
            pres_we = 1'b1;
            pres_wd = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            n_nxt      = store_ok ? cnt_r + CNT_W'(1) : cnt_r;
            rem_nxt    = n_nxt;
            passes_nxt = '0;
            longest_nxt = '0;
            first_nxt  = 1'b1;
            state_nxt  = ST_PASS;
          end
        end
      end

      ST_PASS: begin
        if (rem_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          i_nxt     = '0;
          best_nxt  = '0;
          state_nxt = ST_RDI;
        end
      end

      ST_RDI: begin
        if (i_r == n_r) begin
          // table done: start the backward peel walk
          level_nxt = best_r;
          k_nxt     = n_r;
          pend_nxt  = 1'b0;
          if (first_r) begin
            longest_nxt = best_r;
          end
          state_nxt = ST_PEEL;
        end else begin
          rd_addr   = i_r[ADDR_W-1:0];
          state_nxt = ST_GETI;
        end
      end

      ST_GETI: begin
        vi_nxt = val_q;
        if (!pres_q) begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = ST_RDI;
        end else begin
          t_nxt     = CNT_W'(1);
          j_nxt     = '0;
          pend_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // read of j issued the cycle before its compare
        if (pend_r && take_chain) begin
          t_nxt = tab_inc;
        end
        if (j_r != i_r) begin
          rd_addr  = j_r[ADDR_W-1:0];
          j_nxt    = j_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_WR;
        end
      end

      ST_WR: begin
        tab_we = 1'b1;
        if (t_r > best_r) begin
          best_nxt = t_r;
        end
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = ST_RDI;
      end

      ST_PEEL: begin
        wr_addr = pk_r;
        if (pend_r && pres_q && (tab_q == level_r)) begin
          pres_we   = 1'b1;
          pres_wd   = 1'b0;
          level_nxt = level_r - CNT_W'(1);
          rem_nxt   = rem_r - CNT_W'(1);
        end
        if (k_r != '0) begin
          k_nxt    = k_r - CNT_W'(1);
          rd_addr  = k_nxt[ADDR_W-1:0];
          pk_nxt   = k_nxt[ADDR_W-1:0];
          pend_nxt = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_PEND;
        end
      end

      ST_PEND: begin
        passes_nxt = passes_r + CNT_W'(1);
        first_nxt  = 1'b0;
        state_nxt  = ST_PASS;
      end

      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, ovf_r, OUT_W'(passes_r), OUT_W'(longest_r)};
          cnt_nxt       = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_LOAD;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ASSERT_IMPLIES(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(MAX_ITEMS), "store count past depth")
  `ASSERT_NEXT(a_last_blocks, clk, rst_n, in_tvalid && in_tready && in_tlast, !in_tready, "ready after last item")
  `ASSERT_IMPLIES(a_passes_bound, clk, rst_n, state_r == ST_FIN, (passes_r <= n_r) && (rem_r == '0), "pass count exceeds items")
  `ASSERT_IMPLIES(a_rem_bound, clk, rst_n, state_r == ST_PEEL, rem_r <= n_r, "remaining count exceeds items")

endmodule

`default_nettype wire
